@@ rtl/adfp_pkg.sv @@
// shared types, constants and the hex digit packing function of the air data frame parser
`default_nettype none
package adfp_pkg;

    localparam int WIN_LEN = 11;
    localparam int HDR_LEN = 7;
    localparam int NUM_CHARS = 8;
    localparam int NUM_SLOTS = 4;

    localparam logic [7:0] ADDR_PRIMARY   = 8'h01;
    localparam logic [7:0] ADDR_SECONDARY = 8'h02;
    localparam logic [7:0] KIND_BASE      = 8'h82;
    localparam logic [7:0] KIND_ALT       = 8'h87;

    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [3:0] ALPHA_OFFSET = 4'd9;

    typedef logic [7:0] t_hdr [HDR_LEN];
    localparam t_hdr HDR_PATTERN = '{8'h01, 8'h8F, 8'h30, 8'h30, 8'h30, 8'h30, 8'h0D};

    typedef logic [7:0] t_chars [NUM_CHARS];

    typedef enum logic [1:0] {
        SLOT_PRESSURE      = 2'd0,
        SLOT_STD_ALTITUDE  = 2'd1,
        SLOT_CLIMB_RATE    = 2'd2,
        SLOT_CORR_ALTITUDE = 2'd3
    } t_slot;

    typedef struct packed {
        logic        frame_hit;
        t_slot       slot;
        logic [31:0] word;
        logic        header_hit;
    } t_scan_hit;

    typedef struct packed {
        logic                        header_found;
        logic [NUM_SLOTS-1:0]        valid;
        logic [NUM_SLOTS-1:0][31:0]  bits;
    } t_result;

    function automatic logic [31:0] pack_digits(input t_chars c);
        logic [31:0] word;
        logic [3:0]  d;
        logic        ok;
        word = '0;
        for (int k = 0; k < NUM_CHARS; k++) begin
            d  = 4'h0;
            ok = 1'b0;
            if (c[k] >= CHAR_0 && c[k] <= CHAR_9) begin
                d  = c[k][3:0];
                ok = 1'b1;
            end else if (c[k] >= CHAR_A && c[k] <= CHAR_F) begin
                d  = c[k][3:0] + ALPHA_OFFSET;
                ok = 1'b1;
            end
            if (ok) begin
                word = {word[27:0], d};
            end
        end
        return word;
    endfunction

endpackage
`default_nettype wire

@@ rtl/adfp_scan.sv @@
// sliding byte window with frame decode, digit packing and header match
`default_nettype none
module adfp_scan
    import adfp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire logic      i_last,
    input  wire logic [7:0] i_byte,
    output t_scan_hit      o_hit
);

    localparam logic [3:0] SEEN_MAX = 4'(WIN_LEN);
    localparam logic [3:0] SEEN_HDR = 4'(HDR_LEN);

    logic [7:0] r_win [WIN_LEN];
    logic [7:0] n_win [WIN_LEN];
    logic [3:0] r_seen;
    logic [3:0] n_seen;
    t_chars     chars;
    logic       hdr_match;
    logic       addr_ok;
    logic       kind_ok;

    always_comb begin
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            n_win[k] = r_win[k+1];
        end
        n_win[WIN_LEN-1] = i_byte;
        n_seen = (r_seen == SEEN_MAX) ? r_seen : r_seen + 4'd1;

        for (int k = 0; k < NUM_CHARS; k++) begin
            chars[k] = n_win[k+2];
        end

        hdr_match = 1'b1;
        for (int k = 0; k < HDR_LEN; k++) begin
            if (n_win[WIN_LEN-HDR_LEN+k] != HDR_PATTERN[k]) begin
                hdr_match = 1'b0;
            end
        end

        addr_ok = (n_win[0] == ADDR_PRIMARY) || (n_win[0] == ADDR_SECONDARY);
        kind_ok = (n_win[1] == KIND_BASE) || (n_win[1] == KIND_ALT);

        o_hit.frame_hit  = (n_seen == SEEN_MAX) && addr_ok && kind_ok;
        o_hit.slot       = t_slot'({n_win[0] == ADDR_SECONDARY, n_win[1] == KIND_ALT});
        o_hit.word       = pack_digits(chars);
        o_hit.header_hit = (n_seen >= SEEN_HDR) && hdr_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_step) begin
            r_seen <= i_last ? '0 : n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int k = 0; k < WIN_LEN; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/adfp_accum.sv @@
// per chunk value store and result register
`default_nettype none
module adfp_accum
    import adfp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire logic      i_last,
    input  wire t_scan_hit i_hit,
    input  wire logic      i_take,
    output logic           o_valid,
    output t_result        o_result
);

    logic [NUM_SLOTS-1:0][31:0] r_words;
    logic [NUM_SLOTS-1:0][31:0] n_words;
    logic [NUM_SLOTS-1:0]       r_vseen;
    logic [NUM_SLOTS-1:0]       n_vseen;
    logic                       r_hdr;
    logic                       n_hdr;
    logic                       r_out_valid;
    t_result                    r_res;
    t_result                    n_res;

    always_comb begin
        n_words = r_words;
        n_vseen = r_vseen;
        if (i_hit.frame_hit) begin
            n_words[i_hit.slot] = i_hit.word;
            n_vseen[i_hit.slot] = 1'b1;
        end
        n_hdr = r_hdr | i_hit.header_hit;

        n_res.header_found = n_hdr;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            n_res.valid[k] = n_hdr & n_vseen[k];
            n_res.bits[k]  = (n_hdr & n_vseen[k]) ? n_words[k] : 32'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vseen     <= '0;
            r_hdr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step) begin
                r_vseen <= i_last ? '0 : n_vseen;
                r_hdr   <= i_last ? 1'b0 : n_hdr;
            end
            if (i_step && i_last) begin
                r_out_valid <= 1'b1;
            end else if (i_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_words <= n_words;
        end
        if (i_step && i_last) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

endmodule
`default_nettype wire

@@ rtl/air_data_frame_parser.sv @@
// top level of the air data frame parser: input register, window scan and result register
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------------
//  bytes   | in        | i_valid / o_stall  | i_data_byte, i_chunk_end
//  result  | out       | o_valid / i_stall  | o_header_found, four o_*_bits / o_*_valid pairs
//
//  one byte per cycle; a request is registered, then scanned and folded into the store
//  the result of a chunk is registered once its last byte has passed the input register and the scan
//  only a last byte waits on a stalled result register; other bytes keep flowing
//  synchronous active-low reset clears the fill count, the store flags and both valids
`default_nettype none
module air_data_frame_parser
    import adfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_chunk_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_header_found,
    output logic [31:0]      o_pressure_bits,
    output logic             o_pressure_valid,
    output logic [31:0]      o_std_altitude_bits,
    output logic             o_std_altitude_valid,
    output logic [31:0]      o_climb_rate_bits,
    output logic             o_climb_rate_valid,
    output logic [31:0]      o_corr_altitude_bits,
    output logic             o_corr_altitude_valid
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       blocked;
    logic       step;
    logic       out_valid;
    t_scan_hit  hit;
    t_result    result;

    assign blocked = r_in_end && out_valid && i_stall;
    assign step    = r_in_valid && !blocked;
    assign o_stall = r_in_valid && blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_chunk_end;
        end
    end

    adfp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_last  (r_in_end),
        .i_byte  (r_in_byte),
        .o_hit   (hit)
    );

    adfp_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_last   (r_in_end),
        .i_hit    (hit),
        .i_take   (out_valid && !i_stall),
        .o_valid  (out_valid),
        .o_result (result)
    );

    assign o_valid               = out_valid;
    assign o_header_found        = result.header_found;
    assign o_pressure_bits       = result.bits[SLOT_PRESSURE];
    assign o_pressure_valid      = result.valid[SLOT_PRESSURE];
    assign o_std_altitude_bits   = result.bits[SLOT_STD_ALTITUDE];
    assign o_std_altitude_valid  = result.valid[SLOT_STD_ALTITUDE];
    assign o_climb_rate_bits     = result.bits[SLOT_CLIMB_RATE];
    assign o_climb_rate_valid    = result.valid[SLOT_CLIMB_RATE];
    assign o_corr_altitude_bits  = result.bits[SLOT_CORR_ALTITUDE];
    assign o_corr_altitude_valid = result.valid[SLOT_CORR_ALTITUDE];

endmodule
`default_nettype wire
